### rtl/core/rgm_pkg.sv
// ----------------------------------------------------------------------------
// rgm_pkg
// Shared widths, constants, register indexes and quotient saturation for the
// gamut map to gray pipeline.
// ----------------------------------------------------------------------------
package rgm_pkg;

    localparam int FRAC_BITS = 16;
    localparam int INT_BITS  = 3;
    localparam int VAL_W     = FRAC_BITS + INT_BITS + 1;   // pixel channel
    localparam int WGT_W     = FRAC_BITS + 1;              // weights, factor
    localparam int CFG_IDX_W = 2;
    localparam int Y_W       = VAL_W + 2;                  // luminance
    localparam int D_W       = VAL_W + 3;                  // channel minus luma
    localparam int DEN_W     = D_W + 1;                    // divisor magnitude
    localparam int NUM_W     = D_W + 1 + FRAC_BITS;        // dividend magnitude
    localparam int QT_W      = VAL_W + 1;                  // quotient bits kept
    localparam int DIV_LAT   = QT_W + 1;                   // divider stages
    localparam int TDATA_W   = ((3 * VAL_W + 7) / 8) * 8;

    localparam logic [WGT_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    localparam logic [WGT_W-1:0] RST_WEIGHT_RED   = WGT_W'((64'd13933 << FRAC_BITS) >> 16);
    localparam logic [WGT_W-1:0] RST_WEIGHT_GREEN = WGT_W'((64'd46871 << FRAC_BITS) >> 16);
    localparam logic [WGT_W-1:0] RST_WEIGHT_BLUE  = WGT_W'((64'd4732 << FRAC_BITS) >> 16);
    localparam logic [WGT_W-1:0] RST_SAT_FACTOR   = WGT_W'((64'd19661 << FRAC_BITS) >> 16);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WEIGHT_RED   = 2'd0,
        REG_WEIGHT_GREEN = 2'd1,
        REG_WEIGHT_BLUE  = 2'd2,
        REG_SAT_FACTOR   = 2'd3
    } cfg_idx_t;

    // Apply sign to a quotient magnitude and clamp to the channel range.
    function automatic logic [VAL_W-1:0] sat_quot(input logic [QT_W-1:0] mag,
                                                  input logic            ovf,
                                                  input logic            neg);
        logic [QT_W-1:0] pos_lim;
        logic [QT_W-1:0] neg_lim;
        logic [QT_W-1:0] r;
        pos_lim = QT_W'((64'd1 << (VAL_W - 1)) - 64'd1);
        neg_lim = QT_W'(64'd1 << (VAL_W - 1));
        if (neg) begin
            r = (ovf || mag > neg_lim) ? -neg_lim : -mag;
        end else begin
            r = (ovf || mag > pos_lim) ? pos_lim : mag;
        end
        return r[VAL_W-1:0];
    endfunction

endpackage

### rtl/core/rgm_div.sv
// ----------------------------------------------------------------------------
// rgm_div
// Pipelined restoring divider, one quotient bit per stage. Flags dividends
// whose quotient does not fit the kept quotient bits.
// ----------------------------------------------------------------------------
module rgm_div (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [rgm_pkg::NUM_W-1:0]   num_i,
    input  logic [rgm_pkg::DEN_W-1:0]   den_i,
    output logic [rgm_pkg::QT_W-1:0]    quo_o,
    output logic                        ovf_o
);
    localparam int QT_W  = rgm_pkg::QT_W;
    localparam int NUM_W = rgm_pkg::NUM_W;
    localparam int DEN_W = rgm_pkg::DEN_W;
    localparam int CMP_W = DEN_W + QT_W;

    logic [NUM_W-1:0] rem_reg [0:QT_W-1];
    logic [DEN_W-1:0] den_reg [0:QT_W-1];
    logic [QT_W-1:0]  quo_reg [0:QT_W];
    logic             ovf_reg [0:QT_W];

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= num_i;
            den_reg[0] <= den_i;
            quo_reg[0] <= '0;
            ovf_reg[0] <= (CMP_W'(num_i) >= {den_i, {QT_W{1'b0}}});
        end
    end

    for (genvar k = 1; k <= QT_W; k++) begin : g_bit
        localparam int B = QT_W - k;
        logic [CMP_W-1:0] trial;
        logic             fit;

        assign trial = CMP_W'(den_reg[k-1]) << B;
        assign fit   = CMP_W'(rem_reg[k-1]) >= trial;

        always_ff @(posedge aclk) begin
            if (en) begin
                quo_reg[k] <= quo_reg[k-1] | (fit ? (QT_W'(1) << B) : '0);
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end

        if (k < QT_W) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k] <= fit ? NUM_W'(CMP_W'(rem_reg[k-1]) - trial)
                                      : rem_reg[k-1];
                    den_reg[k] <= den_reg[k-1];
                end
            end
        end
    end

    assign quo_o = quo_reg[QT_W];
    assign ovf_o = ovf_reg[QT_W];

endmodule

### rtl/core/rgb_gamut_map_to_gray.sv
// Pipeline: 2 * 22 divider stages plus 12 arithmetic and register stages
//   from input beat to output beat.
// Throughput: one pixel per cycle; a stalled output holds the whole pipe.
// The two ranks of 22-stage restoring dividers set the depth.
// Reset clears all valid bits and loads the default weights and factor.
// ----------------------------------------------------------------------------
// rgb_gamut_map_to_gray
// Luminance preserving gamut map: desaturates each pixel toward its luma so
// that it fits the [0,1] range, then divides by the largest channel if above 1.
// ----------------------------------------------------------------------------
module rgb_gamut_map_to_gray (
    input  logic                            aclk,
    input  logic                            aresetn,
    // s_tdata: red_in, green_in, blue_in (lowest bit first)
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rgm_pkg::TDATA_W-1:0]     s_tdata,
    input  logic                            s_tlast,
    // m_tdata: red_out, green_out, blue_out (lowest bit first)
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rgm_pkg::TDATA_W-1:0]     m_tdata,
    output logic                            m_tlast,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rgm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rgm_pkg::WGT_W-1:0]       cfg_data
);
    localparam int F       = rgm_pkg::FRAC_BITS;
    localparam int VAL_W   = rgm_pkg::VAL_W;
    localparam int WGT_W   = rgm_pkg::WGT_W;
    localparam int Y_W     = rgm_pkg::Y_W;
    localparam int D_W     = rgm_pkg::D_W;
    localparam int DEN_W   = rgm_pkg::DEN_W;
    localparam int NUM_W   = rgm_pkg::NUM_W;
    localparam int QT_W    = rgm_pkg::QT_W;
    localparam int DL      = rgm_pkg::DIV_LAT;
    localparam int NW1     = NUM_W + 1;
    localparam int PRD_W   = VAL_W + WGT_W + 1;
    localparam int SUM_W   = PRD_W + 2;
    localparam int SFP_W   = WGT_W + 1 + VAL_W + 1;
    localparam int MIX_W   = VAL_W + 4;
    localparam int MP_W    = WGT_W + 1 + D_W;
    localparam int MX_W    = D_W + 1;
    localparam int NSTG    = 12 + 2 * DL;
    localparam int S_SAT   = 5 + DL;
    localparam int S_MIX   = 7 + DL;
    localparam int S_MAXV  = 10 + DL;

    localparam logic signed [SUM_W-1:0] HALF_SUM = SUM_W'(64'd1 << (F - 1));
    localparam logic signed [SFP_W-1:0] HALF_SFP = SFP_W'(64'd1 << (F - 1));
    localparam logic signed [MP_W-1:0]  HALF_MP  = MP_W'(64'd1 << (F - 1));
    localparam logic signed [D_W-1:0]   ONE_D    = D_W'(rgm_pkg::ONE);
    localparam logic signed [NW1-1:0]   ONE_N    = NW1'(rgm_pkg::ONE);
    localparam logic signed [MIX_W-1:0] ONE_MIX  = MIX_W'(rgm_pkg::ONE);
    localparam logic signed [MX_W-1:0]  ONE_MX   = MX_W'(rgm_pkg::ONE);
    localparam logic signed [VAL_W-1:0] ONE_V    = VAL_W'(rgm_pkg::ONE);

    typedef struct packed {
        logic [2:0]           dneg;
        logic [2:0]           dzero;
        logic [2:0]           negq;
        logic [2:0]           negl;
        logic [3*VAL_W-1:0]   ch;
        logic [Y_W-1:0]       y;
        logic                 last;
    } dly1_t;

    typedef struct packed {
        logic [3*VAL_W-1:0]   ch;
        logic [Y_W-1:0]       y;
        logic                 last;
    } carry_t;

    typedef struct packed {
        logic [2:0]           neg;
        logic                 last;
    } dly2_t;

    // ---------------- configuration
    logic [WGT_W-1:0] wgt_reg [3];
    logic [WGT_W-1:0] sf_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wgt_reg[0] <= rgm_pkg::RST_WEIGHT_RED;
            wgt_reg[1] <= rgm_pkg::RST_WEIGHT_GREEN;
            wgt_reg[2] <= rgm_pkg::RST_WEIGHT_BLUE;
            sf_reg     <= rgm_pkg::RST_SAT_FACTOR;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                rgm_pkg::REG_WEIGHT_RED:   wgt_reg[0] <= cfg_data;
                rgm_pkg::REG_WEIGHT_GREEN: wgt_reg[1] <= cfg_data;
                rgm_pkg::REG_WEIGHT_BLUE:  wgt_reg[2] <= cfg_data;
                rgm_pkg::REG_SAT_FACTOR:   sf_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control
    logic [NSTG-1:0] vld_reg;
    logic            en;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[NSTG-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NSTG-2:0], s_tvalid};
        end
    end

    // ---------------- stages 1-3: input, weight products, luma
    logic signed [VAL_W-1:0] ch1_reg [3];
    logic signed [VAL_W-1:0] ch2_reg [3];
    logic signed [VAL_W-1:0] ch3_reg [3];
    logic signed [PRD_W-1:0] prod2_reg [3];
    logic signed [SUM_W-1:0] sum_next;
    logic signed [SUM_W-1:0] sum_rnd;
    logic signed [Y_W-1:0]   y3_reg;
    logic                    last1_reg, last2_reg, last3_reg;

    assign sum_next = SUM_W'(prod2_reg[0]) + SUM_W'(prod2_reg[1])
                    + SUM_W'(prod2_reg[2]) + HALF_SUM;
    assign sum_rnd  = sum_next >>> F;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                ch1_reg[c]   <= s_tdata[c*VAL_W +: VAL_W];
                ch2_reg[c]   <= ch1_reg[c];
                ch3_reg[c]   <= ch2_reg[c];
                prod2_reg[c] <= ch1_reg[c] * $signed({1'b0, wgt_reg[c]});
            end
            last1_reg <= s_tlast;
            last2_reg <= last1_reg;
            last3_reg <= last2_reg;
            y3_reg    <= sum_rnd[Y_W-1:0];
        end
    end

    // ---------------- stage 4: differences and dividend / divisor magnitudes
    logic signed [D_W-1:0]   d4_w    [3];
    logic signed [D_W-1:0]   dv4_w   [3];
    logic signed [DEN_W-1:0] dve4_w  [3];
    logic signed [NW1-1:0]   nq4_w   [3];
    logic signed [NW1-1:0]   nl4_w   [3];
    logic [NUM_W-1:0]        numq4_reg [3];
    logic [NUM_W-1:0]        numl4_reg [3];
    logic [DEN_W-1:0]        den4_reg  [3];
    dly1_t                   p4_next;
    dly1_t                   p4_reg;

    always_comb begin
        p4_next.last = last3_reg;
        p4_next.y    = y3_reg;
        for (int c = 0; c < 3; c++) begin
            d4_w[c]   = D_W'(ch3_reg[c]) - D_W'(y3_reg);
            dv4_w[c]  = (d4_w[c] == '0) ? ONE_D : d4_w[c];
            dve4_w[c] = DEN_W'(dv4_w[c]);
            nq4_w[c]  = NW1'(ch3_reg[c]) <<< F;
            nl4_w[c]  = (NW1'(ch3_reg[c]) - ONE_N) <<< F;
            p4_next.dneg[c]  = d4_w[c][D_W-1];
            p4_next.dzero[c] = (d4_w[c] == '0);
            p4_next.negq[c]  = nq4_w[c][NUM_W] ^ dv4_w[c][D_W-1];
            p4_next.negl[c]  = nl4_w[c][NUM_W] ^ dv4_w[c][D_W-1];
            p4_next.ch[c*VAL_W +: VAL_W] = ch3_reg[c];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                numq4_reg[c] <= nq4_w[c][NUM_W] ? NUM_W'(-nq4_w[c]) : NUM_W'(nq4_w[c]);
                numl4_reg[c] <= nl4_w[c][NUM_W] ? NUM_W'(-nl4_w[c]) : NUM_W'(nl4_w[c]);
                den4_reg[c]  <= dve4_w[c][DEN_W-1] ? DEN_W'(-dve4_w[c])
                                                   : DEN_W'(dve4_w[c]);
            end
            p4_reg <= p4_next;
        end
    end

    // ---------------- ratio dividers
    logic [QT_W-1:0] quoq_w [3];
    logic [QT_W-1:0] quol_w [3];
    logic            ovfq_w [3];
    logic            ovfl_w [3];
    dly1_t           dly1_reg [0:DL-1];

    for (genvar c = 0; c < 3; c++) begin : g_ratio
        rgm_div u_div_q (
            .aclk  (aclk),
            .en    (en),
            .num_i (numq4_reg[c]),
            .den_i (den4_reg[c]),
            .quo_o (quoq_w[c]),
            .ovf_o (ovfq_w[c])
        );
        rgm_div u_div_l (
            .aclk  (aclk),
            .en    (en),
            .num_i (numl4_reg[c]),
            .den_i (den4_reg[c]),
            .quo_o (quol_w[c]),
            .ovf_o (ovfl_w[c])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dly1_reg[0] <= p4_reg;
            for (int i = 1; i < DL; i++) begin
                dly1_reg[i] <= dly1_reg[i-1];
            end
        end
    end

    // ---------------- stage 5: saturated ratios
    logic signed [VAL_W-1:0] q5_reg  [3];
    logic signed [VAL_W-1:0] ql5_reg [3];
    dly1_t                   p5_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                q5_reg[c]  <= rgm_pkg::sat_quot(quoq_w[c], ovfq_w[c], dly1_reg[DL-1].negq[c]);
                ql5_reg[c] <= rgm_pkg::sat_quot(quol_w[c], ovfl_w[c], dly1_reg[DL-1].negl[c]);
            end
            p5_reg <= dly1_reg[DL-1];
        end
    end

    // ---------------- stage 6: saturation and luminance bounds
    logic signed [VAL_W-1:0] sat_next, lum_next, cand_w;
    logic signed [VAL_W-1:0] sat6_reg, lum6_reg;
    carry_t                  car6_reg;

    always_comb begin
        sat_next = '0;
        lum_next = '0;
        cand_w   = '0;
        for (int c = 0; c < 3; c++) begin
            if (p5_reg.dneg[c] && q5_reg[c] > sat_next) begin
                sat_next = q5_reg[c];
            end
            cand_w = (p5_reg.dneg[c] || p5_reg.dzero[c]) ? sat_next : ql5_reg[c];
            if (cand_w > lum_next) begin
                lum_next = cand_w;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sat6_reg      <= sat_next;
            lum6_reg      <= lum_next;
            car6_reg.ch   <= p5_reg.ch;
            car6_reg.y    <= p5_reg.y;
            car6_reg.last <= p5_reg.last;
        end
    end

    // ---------------- stages 7-8: blend the bounds, clamp to [0,1]
    logic signed [VAL_W:0]   diff7_w;
    logic signed [SFP_W-1:0] sfp7_reg;
    logic signed [VAL_W-1:0] lum7_reg;
    carry_t                  car7_reg;
    logic signed [SFP_W-1:0] rnd8_w;
    logic signed [MIX_W-1:0] mix8_w;
    logic [WGT_W-1:0]        mix8_reg;
    carry_t                  car8_reg;

    assign diff7_w = (VAL_W+1)'(sat6_reg) - (VAL_W+1)'(lum6_reg);
    assign rnd8_w  = (sfp7_reg + HALF_SFP) >>> F;
    assign mix8_w  = MIX_W'(lum7_reg) + rnd8_w[MIX_W-1:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            sfp7_reg <= $signed({1'b0, sf_reg}) * diff7_w;
            lum7_reg <= lum6_reg;
            car7_reg <= car6_reg;
            if (mix8_w > ONE_MIX) begin
                mix8_reg <= rgm_pkg::ONE;
            end else if (mix8_w < 0) begin
                mix8_reg <= '0;
            end else begin
                mix8_reg <= mix8_w[WGT_W-1:0];
            end
            car8_reg <= car7_reg;
        end
    end

    // ---------------- stages 9-10: mix each channel toward luma
    logic signed [D_W-1:0]  yd9_w  [3];
    logic signed [MP_W-1:0] mp9_reg [3];
    carry_t                 car9_reg;
    logic signed [MP_W-1:0] rnd10_w [3];
    logic signed [MX_W-1:0] mixed10_reg [3];
    logic                   last10_reg;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            yd9_w[c]   = D_W'($signed(car8_reg.y))
                       - D_W'($signed(car8_reg.ch[c*VAL_W +: VAL_W]));
            rnd10_w[c] = (mp9_reg[c] + HALF_MP) >>> F;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                mp9_reg[c]     <= $signed({1'b0, mix8_reg}) * yd9_w[c];
                mixed10_reg[c] <= MX_W'($signed(car9_reg.ch[c*VAL_W +: VAL_W]))
                                + rnd10_w[c][MX_W-1:0];
            end
            car9_reg   <= car8_reg;
            last10_reg <= car9_reg.last;
        end
    end

    // ---------------- stage 11: normalizer and dividends
    logic signed [MX_W-1:0] maxv_w;
    logic signed [NW1-1:0]  nm11_w [3];
    logic [NUM_W-1:0]       num11_reg [3];
    logic signed [MX_W-1:0] maxv11_reg;
    dly2_t                  p11_reg;

    always_comb begin
        maxv_w = ONE_MX;
        for (int c = 0; c < 3; c++) begin
            if (mixed10_reg[c] > maxv_w) begin
                maxv_w = mixed10_reg[c];
            end
            nm11_w[c] = NW1'(mixed10_reg[c]) <<< F;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                num11_reg[c]  <= nm11_w[c][NUM_W] ? NUM_W'(-nm11_w[c]) : NUM_W'(nm11_w[c]);
                p11_reg.neg[c] <= mixed10_reg[c][MX_W-1];
            end
            maxv11_reg   <= maxv_w;
            p11_reg.last <= last10_reg;
        end
    end

    // ---------------- normalizing dividers and output register
    logic [QT_W-1:0]         quon_w [3];
    logic                    ovfn_w [3];
    dly2_t                   dly2_reg [0:DL-1];
    logic signed [VAL_W-1:0] out_reg [3];
    logic                    last_out_reg;

    for (genvar c = 0; c < 3; c++) begin : g_norm
        rgm_div u_div_n (
            .aclk  (aclk),
            .en    (en),
            .num_i (num11_reg[c]),
            .den_i (DEN_W'(maxv11_reg)),
            .quo_o (quon_w[c]),
            .ovf_o (ovfn_w[c])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dly2_reg[0] <= p11_reg;
            for (int i = 1; i < DL; i++) begin
                dly2_reg[i] <= dly2_reg[i-1];
            end
            for (int c = 0; c < 3; c++) begin
                out_reg[c] <= rgm_pkg::sat_quot(quon_w[c], ovfn_w[c], dly2_reg[DL-1].neg[c]);
            end
            last_out_reg <= dly2_reg[DL-1].last;
        end
    end

    assign m_tdata = rgm_pkg::TDATA_W'({out_reg[2], out_reg[1], out_reg[0]});
    assign m_tlast = last_out_reg;

    // ---------------- checks
    a_out_le_one: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_reg[0] <= ONE_V && out_reg[1] <= ONE_V && out_reg[2] <= ONE_V))
        else $error("output channel above 1.0");

    a_bounds_nonneg: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[S_SAT] |-> (sat6_reg >= 0 && lum6_reg >= 0))
        else $error("negative saturation or luminance bound");

    a_mix_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[S_MIX] |-> (mix8_reg <= rgm_pkg::ONE))
        else $error("mix amount above 1.0");

    a_maxv_ge_one: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[S_MAXV] |-> (maxv11_reg >= ONE_MX))
        else $error("normalizer below 1.0");

endmodule

### test/rgm_checker.sv
// ----------------------------------------------------------------------------
// rgm_checker
// Watches the pixel and register channels of the gamut map, computes the
// expected mapped pixel for every accepted input beat and compares each
// output beat against the oldest expected pixel.
// ----------------------------------------------------------------------------
module rgm_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [rgm_pkg::TDATA_W-1:0]       s_tdata,
    input  logic                              s_tlast,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [rgm_pkg::TDATA_W-1:0]       m_tdata,
    input  logic                              m_tlast,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [rgm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rgm_pkg::WGT_W-1:0]         cfg_data,
    output int                                fail_count,
    output int                                pending
);

    localparam int VAL_W     = rgm_pkg::VAL_W;
    localparam int WGT_W     = rgm_pkg::WGT_W;
    localparam int FRAC_BITS = rgm_pkg::FRAC_BITS;

    typedef struct packed {
        logic             last;
        logic [VAL_W-1:0] b;
        logic [VAL_W-1:0] g;
        logic [VAL_W-1:0] r;
    } pixel_t;

    localparam longint UNIT   = longint'(1) << FRAC_BITS;
    localparam longint CH_MAX = (longint'(1) << (VAL_W - 1)) - 1;
    localparam longint CH_MIN = -(longint'(1) << (VAL_W - 1));

    logic [WGT_W-1:0] w_red, w_green, w_blue, sat_fac;
    pixel_t           expected_px[$];

    function automatic longint clamp_ch(longint x);
        if (x > CH_MAX) return CH_MAX;
        if (x < CH_MIN) return CH_MIN;
        return x;
    endfunction

    // floor of x / 2^FRAC_BITS after adding one half
    function automatic longint rnd(longint x);
        return (x + (UNIT >>> 1)) >>> FRAC_BITS;
    endfunction

    function automatic pixel_t map_pixel(pixel_t px);
        longint c[3], mx[3];
        longint y, sat, lum, mix, peak, v, d, dv, q, ql;
        pixel_t o;
        c[0] = longint'($signed(px.r));
        c[1] = longint'($signed(px.g));
        c[2] = longint'($signed(px.b));
        y = rnd(c[0] * longint'(w_red) + c[1] * longint'(w_green)
                + c[2] * longint'(w_blue));
        sat = 0;
        lum = 0;
        for (int i = 0; i < 3; i++) begin
            v  = c[i];
            d  = v - y;
            dv = (d == 0) ? UNIT : d;
            q  = clamp_ch((v * UNIT) / dv);
            ql = clamp_ch(((v - UNIT) * UNIT) / dv);
            if (d < 0 && q > sat) sat = q;
            if (d <= 0) begin
                if (sat > lum) lum = sat;
            end else if (ql > lum) begin
                lum = ql;
            end
        end
        mix = lum + rnd(longint'(sat_fac) * (sat - lum));
        if (mix > UNIT) mix = UNIT;
        if (mix < 0) mix = 0;
        peak = UNIT;
        for (int i = 0; i < 3; i++) begin
            mx[i] = c[i] + rnd(mix * (y - c[i]));
            if (mx[i] > peak) peak = mx[i];
        end
        o.r = VAL_W'(clamp_ch((mx[0] * UNIT) / peak));
        o.g = VAL_W'(clamp_ch((mx[1] * UNIT) / peak));
        o.b = VAL_W'(clamp_ch((mx[2] * UNIT) / peak));
        o.last = px.last;
        return o;
    endfunction

    always @(posedge aclk) begin
        pixel_t inpx, got, want;
        if (!aresetn) begin
            w_red   <= rgm_pkg::RST_WEIGHT_RED;
            w_green <= rgm_pkg::RST_WEIGHT_GREEN;
            w_blue  <= rgm_pkg::RST_WEIGHT_BLUE;
            sat_fac <= rgm_pkg::RST_SAT_FACTOR;
            fail_count <= 0;
            pending    <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (rgm_pkg::cfg_idx_t'(cfg_index))
                    rgm_pkg::REG_WEIGHT_RED:   w_red   <= cfg_data;
                    rgm_pkg::REG_WEIGHT_GREEN: w_green <= cfg_data;
                    rgm_pkg::REG_WEIGHT_BLUE:  w_blue  <= cfg_data;
                    rgm_pkg::REG_SAT_FACTOR:   sat_fac <= cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                inpx = {s_tlast, s_tdata[3*VAL_W-1:0]};
                expected_px.push_back(map_pixel(inpx));
            end
            if (m_tvalid && m_tready) begin
                got = {m_tlast, m_tdata[3*VAL_W-1:0]};
                if (expected_px.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected output beat %h", got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_px.pop_front();
                    if (got !== want) begin
                        if (fail_count < 10)
                            $display("mismatch: exp r=%h g=%h b=%h l=%b got r=%h g=%h b=%h l=%b",
                                     want.r, want.g, want.b, want.last,
                                     got.r, got.g, got.b, got.last);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= expected_px.size();
        end
    end

endmodule

### test/tb_rgb_gamut_map_to_gray.sv
// ----------------------------------------------------------------------------
// tb_rgb_gamut_map_to_gray
// Drives directed and random pixels through the gamut map under several
// weight and factor settings, with random input gaps, output backpressure
// and one long output stall; the checker does all comparison.
// ----------------------------------------------------------------------------
module tb_rgb_gamut_map_to_gray;

    localparam int TDATA_W   = rgm_pkg::TDATA_W;
    localparam int CFG_IDX_W = rgm_pkg::CFG_IDX_W;
    localparam int WGT_W     = rgm_pkg::WGT_W;
    localparam int VAL_W     = rgm_pkg::VAL_W;
    localparam int DUT_LAT   = 56;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [TDATA_W-1:0]    s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [TDATA_W-1:0]    m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [WGT_W-1:0]      cfg_data;
    int                    fail_count;
    int                    pending;
    bit                    calm;       // no idling while set
    bit                    hold_out;   // long output stall
    bit                    out_done;

    rgb_gamut_map_to_gray dut (.*);

    rgm_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #40000000;
        $display("TB_ERROR");
        $finish;
    end

    // output side backpressure
    initial begin
        m_tready = 1'b0;
        @(posedge aclk iff aresetn);
        while (!out_done) begin
            if (hold_out) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_out = 1'b0;
            end
            m_tready <= calm || ($urandom_range(99) >= 29);
            @(posedge aclk);
        end
    end

    task automatic write_reg(rgm_pkg::cfg_idx_t idx, logic [WGT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_pixel(logic [VAL_W-1:0] r, logic [VAL_W-1:0] g,
                              logic [VAL_W-1:0] b, logic last);
        while (!calm && $urandom_range(99) < 29) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_W'({b, g, r});
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DUT_LAT + 8) @(posedge aclk);
    endtask

    function automatic logic [VAL_W-1:0] rand_ch();
        case ($urandom_range(5))
            0: return VAL_W'($urandom);
            1: return VAL_W'($urandom_range(65536));
            2: return VAL_W'(-$urandom_range(8192));
            3: return VAL_W'($urandom_range(2 * 65536));
            4: return $urandom_range(1) ? {1'b0, {(VAL_W-1){1'b1}}}
                                        : {1'b1, {(VAL_W-1){1'b0}}};
            default: return VAL_W'($urandom_range(65536) - 32768);
        endcase
    endfunction

    task automatic random_pixels(int n);
        logic [VAL_W-1:0] r, g, b;
        for (int i = 0; i < n; i++) begin
            r = rand_ch();
            // gray pixels exercise the zero-difference path
            if ($urandom_range(9) == 0) begin
                g = r;
                b = r;
            end else begin
                g = rand_ch();
                b = rand_ch();
            end
            send_pixel(r, g, b, 1'($urandom_range(1)));
        end
    endtask

    localparam logic [VAL_W-1:0] VMAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] VMIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic [VAL_W-1:0] V1   = VAL_W'(65536);

    initial begin
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = rgm_pkg::REG_WEIGHT_RED;
        cfg_data = '0;
        calm = 1'b0;
        hold_out = 1'b0;
        out_done = 1'b0;
        aresetn = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset weights
        send_pixel('0, '0, '0, 1'b0);
        send_pixel(V1, V1, V1, 1'b1);
        send_pixel(VMAX, VMAX, VMAX, 1'b0);
        send_pixel(VMIN, VMIN, VMIN, 1'b1);
        send_pixel(VMAX, VMIN, '0, 1'b0);
        send_pixel(VMIN, VMAX, V1, 1'b1);
        send_pixel(V1, '0, '0, 1'b0);
        send_pixel('0, V1, '0, 1'b0);
        send_pixel('0, '0, V1, 1'b1);
        send_pixel(VAL_W'(2 * 65536), VAL_W'(-1000), VAL_W'(30000), 1'b0);
        send_pixel(VAL_W'(-65536), VAL_W'(200000), VAL_W'(1), 1'b1);
        send_pixel(VMIN, '0, '0, 1'b0);
        drain();

        // extremes: weights and factor at full scale
        write_reg(rgm_pkg::REG_WEIGHT_RED, rgm_pkg::ONE);
        write_reg(rgm_pkg::REG_WEIGHT_GREEN, rgm_pkg::ONE);
        write_reg(rgm_pkg::REG_WEIGHT_BLUE, rgm_pkg::ONE);
        write_reg(rgm_pkg::REG_SAT_FACTOR, rgm_pkg::ONE);
        send_pixel(VMIN, VMIN, VMIN, 1'b0);
        send_pixel(VMAX, VMAX, VMAX, 1'b1);
        send_pixel(VMAX, VMIN, V1, 1'b0);
        random_pixels(300);
        drain();

        // all zero
        write_reg(rgm_pkg::REG_WEIGHT_RED, '0);
        write_reg(rgm_pkg::REG_WEIGHT_GREEN, '0);
        write_reg(rgm_pkg::REG_WEIGHT_BLUE, '0);
        write_reg(rgm_pkg::REG_SAT_FACTOR, '0);
        send_pixel(VMAX, VMIN, V1, 1'b0);
        random_pixels(250);
        drain();

        // random settings, with a long output stall and a calm stretch
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(rgm_pkg::REG_WEIGHT_RED, WGT_W'($urandom_range(65536)));
            write_reg(rgm_pkg::REG_WEIGHT_GREEN, WGT_W'($urandom_range(65536)));
            write_reg(rgm_pkg::REG_WEIGHT_BLUE, WGT_W'($urandom_range(65536)));
            write_reg(rgm_pkg::REG_SAT_FACTOR, WGT_W'($urandom_range(65536)));
            if (ph == 1) hold_out = 1'b1;
            calm = (ph == 2);
            random_pixels(250);
            calm = 1'b0;
            drain();
        end

        // back to the usual luma weights
        write_reg(rgm_pkg::REG_WEIGHT_RED, rgm_pkg::RST_WEIGHT_RED);
        write_reg(rgm_pkg::REG_WEIGHT_GREEN, rgm_pkg::RST_WEIGHT_GREEN);
        write_reg(rgm_pkg::REG_WEIGHT_BLUE, rgm_pkg::RST_WEIGHT_BLUE);
        write_reg(rgm_pkg::REG_SAT_FACTOR, rgm_pkg::RST_SAT_FACTOR);
        random_pixels(230);
        drain();
        out_done = 1'b1;

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
